// ===== design/rhsv_pkg.sv =====
package rhsv_pkg;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

endpackage

// ===== design/rgb_to_hsv_pixel.sv =====
// results: a pixel transferred at a clock edge passes the input, max / min, divider and output
//   registers, and its result shows on the output ports, marked by o_valid for one cycle
// throughput: one pixel per clock, set by two restoring dividers that produce
//   one quotient bit per pipeline stage; busy is always low
// reset: synchronous, active low, clears the valid bits of every stage
module rgb_to_hsv_pixel
    import rhsv_pkg::*;
#(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CHANNEL_BITS-1:0]  i_red_level,
    input  logic [CHANNEL_BITS-1:0]  i_green_level,
    input  logic [CHANNEL_BITS-1:0]  i_blue_level,
    output logic                     o_valid,
    output logic [FRACTION_BITS-1:0] o_hue_turn,
    output logic [FRACTION_BITS-1:0] o_saturation_level,
    output logic [CHANNEL_BITS-1:0]  o_brightness_level
);

    localparam int CB = CHANNEL_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int HW = CB + 3;

    // input stage
    logic          r_a_valid;
    logic [CB-1:0] r_a_r, r_a_g, r_a_b;

    // max / min stage
    logic          r_b_valid;
    logic [CB-1:0] r_b_r, r_b_g, r_b_b, r_b_mx, r_b_mn;
    t_sector       r_b_sec;
    logic [CB-1:0] n_b_mx, n_b_mn;
    t_sector       n_b_sec;

    // divider stages, index 0 holds the prepared operands
    logic          r_v     [0:FB];
    logic [HW-1:0] r_hrem  [0:FB];
    logic [HW-1:0] r_hdiv  [0:FB];
    logic [FB-1:0] r_hq    [0:FB];
    logic [CB-1:0] r_srem  [0:FB];
    logic [CB-1:0] r_mx    [0:FB];
    logic [FB-1:0] r_sq    [0:FB];
    logic          r_grey  [0:FB];
    logic          r_sfull [0:FB];
    logic          r_szero [0:FB];

    logic [CB-1:0] n_diff;
    logic [HW-1:0] n_dext, n_div6, n_numer;

    logic          r_out_valid;
    logic [FB-1:0] r_out_hue, r_out_sat;
    logic [CB-1:0] r_out_bright;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start && !busy;
        end
        r_a_r <= i_red_level;
        r_a_g <= i_green_level;
        r_a_b <= i_blue_level;
    end

    always_comb begin
        if (r_a_r >= r_a_g && r_a_r >= r_a_b) begin
            n_b_sec = SEC_RED;
            n_b_mx  = r_a_r;
        end else if (r_a_g >= r_a_b) begin
            n_b_sec = SEC_GREEN;
            n_b_mx  = r_a_g;
        end else begin
            n_b_sec = SEC_BLUE;
            n_b_mx  = r_a_b;
        end
        n_b_mn = r_a_r;
        if (r_a_g < n_b_mn) begin
            n_b_mn = r_a_g;
        end
        if (r_a_b < n_b_mn) begin
            n_b_mn = r_a_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_r   <= r_a_r;
        r_b_g   <= r_a_g;
        r_b_b   <= r_a_b;
        r_b_mx  <= n_b_mx;
        r_b_mn  <= n_b_mn;
        r_b_sec <= n_b_sec;
    end

    // numerator folded into one turn, below the divisor 6 * diff whenever diff is nonzero
    always_comb begin
        n_diff = r_b_mx - r_b_mn;
        n_dext = HW'(n_diff);
        n_div6 = (n_dext << 2) + (n_dext << 1);
        case (r_b_sec)
            SEC_GREEN: n_numer = (n_dext << 1) + HW'(r_b_b) - HW'(r_b_r);
            SEC_BLUE:  n_numer = (n_dext << 2) + HW'(r_b_r) - HW'(r_b_g);
            default: begin
                if (r_b_g >= r_b_b) begin
                    n_numer = HW'(r_b_g) - HW'(r_b_b);
                end else begin
                    n_numer = n_div6 + HW'(r_b_g) - HW'(r_b_b);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_b_valid;
        end
        r_hrem[0]  <= n_numer;
        r_hdiv[0]  <= n_div6;
        r_hq[0]    <= '0;
        r_srem[0]  <= n_diff;
        r_mx[0]    <= r_b_mx;
        r_sq[0]    <= '0;
        r_grey[0]  <= (n_diff == '0);
        r_sfull[0] <= (n_diff == r_b_mx);
        r_szero[0] <= (r_b_mx == '0);
    end

    for (genvar s = 1; s <= FB; s++) begin : g_div
        logic [HW:0] n_hsh;
        logic        n_hge;
        logic [HW:0] n_hsub;
        logic [CB:0] n_ssh;
        logic        n_sge;
        logic [CB:0] n_ssub;

        always_comb begin
            n_hsh  = {r_hrem[s-1], 1'b0};
            n_hge  = (n_hsh >= {1'b0, r_hdiv[s-1]});
            n_hsub = n_hge ? (n_hsh - {1'b0, r_hdiv[s-1]}) : n_hsh;
            n_ssh  = {r_srem[s-1], 1'b0};
            n_sge  = (n_ssh >= {1'b0, r_mx[s-1]});
            n_ssub = n_sge ? (n_ssh - {1'b0, r_mx[s-1]}) : n_ssh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= r_v[s-1];
            end
            r_hrem[s]  <= n_hsub[HW-1:0];
            r_hdiv[s]  <= r_hdiv[s-1];
            r_hq[s]    <= {r_hq[s-1][FB-2:0], n_hge};
            r_srem[s]  <= n_ssub[CB-1:0];
            r_mx[s]    <= r_mx[s-1];
            r_sq[s]    <= {r_sq[s-1][FB-2:0], n_sge};
            r_grey[s]  <= r_grey[s-1];
            r_sfull[s] <= r_sfull[s-1];
            r_szero[s] <= r_szero[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_v[FB];
        end
        r_out_hue    <= r_grey[FB] ? '0 : r_hq[FB];
        r_out_bright <= r_mx[FB];
        if (r_szero[FB]) begin
            r_out_sat <= '0;
        end else if (r_sfull[FB]) begin
            r_out_sat <= '1;
        end else begin
            r_out_sat <= r_sq[FB];
        end
    end

    assign o_valid            = r_out_valid;
    assign o_hue_turn         = r_out_hue;
    assign o_saturation_level = r_out_sat;
    assign o_brightness_level = r_out_bright;

endmodule

// ===== design/rhsv_checker.sv =====
module rhsv_checker #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [CHANNEL_BITS-1:0]  i_red_level,
    input logic [CHANNEL_BITS-1:0]  i_green_level,
    input logic [CHANNEL_BITS-1:0]  i_blue_level,
    input logic                     o_valid,
    input logic [FRACTION_BITS-1:0] o_hue_turn,
    input logic [FRACTION_BITS-1:0] o_saturation_level,
    input logic [CHANNEL_BITS-1:0]  o_brightness_level
);

    localparam int LAT = FRACTION_BITS + 4;

    logic                    w_xfer;
    logic [CHANNEL_BITS-1:0] w_max, w_min;

    assign w_xfer = start && !busy;

    always_comb begin
        w_max = i_red_level;
        w_min = i_red_level;
        if (i_green_level > w_max) begin
            w_max = i_green_level;
        end
        if (i_blue_level > w_max) begin
            w_max = i_blue_level;
        end
        if (i_green_level < w_min) begin
            w_min = i_green_level;
        end
        if (i_blue_level < w_min) begin
            w_min = i_blue_level;
        end
    end

    // every result traces back to an earlier input transfer
    a_result_has_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_xfer, LAT))
        else $error("result without matching input transfer");

    a_brightness: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_brightness_level == $past(w_max, LAT)))
        else $error("brightness differs from largest channel");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(w_max, LAT) == $past(w_min, LAT)))
            |-> (o_hue_turn == '0 && o_saturation_level == '0))
        else $error("grey pixel with nonzero hue or saturation");

    a_full_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(w_min, LAT) == '0) && ($past(w_max, LAT) != '0))
            |-> (o_saturation_level == '1))
        else $error("pure color not fully saturated");

endmodule

bind rgb_to_hsv_pixel rhsv_checker #(
    .CHANNEL_BITS  (CHANNEL_BITS),
    .FRACTION_BITS (FRACTION_BITS)
) u_rhsv_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .i_red_level        (i_red_level),
    .i_green_level      (i_green_level),
    .i_blue_level       (i_blue_level),
    .o_valid            (o_valid),
    .o_hue_turn         (o_hue_turn),
    .o_saturation_level (o_saturation_level),
    .o_brightness_level (o_brightness_level)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import rhsv_pkg::*;

    localparam int CH      = 8;
    localparam int FR      = 16;
    localparam int LATENCY = FR + 3;

    localparam logic [3*CH-1:0] CORNER_PIXELS [24] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
        24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'h010000,
        24'hFFFEFE, 24'h010100, 24'h000101, 24'h010001,
        24'hFF00FE, 24'hFEFF00, 24'h00FEFF, 24'h000100,
        24'h000001, 24'hAA5500, 24'h55AAFF, 24'hC86432
    };

    typedef struct packed {
        logic [FR-1:0] hue;
        logic [FR-1:0] sat;
        logic [CH-1:0] bright;
    } hsv_t;

    class hsv_tracker;
        hsv_t expected_hsv[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        function hsv_t hsv_of(logic [CH-1:0] r, logic [CH-1:0] g, logic [CH-1:0] b);
            hsv_t          res;
            logic [CH-1:0] mx;
            logic [CH-1:0] mn;
            logic [CH-1:0] diff;
            t_sector       sec;
            logic [31:0]   numer;
            logic [31:0]   quot;
            mx  = r;
            sec = SEC_RED;
            if (g > mx) begin
                mx  = g;
                sec = SEC_GREEN;
            end
            if (b > mx) begin
                mx  = b;
                sec = SEC_BLUE;
            end
            mn = r;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            diff    = mx - mn;
            res.hue = '0;
            res.sat = '0;
            if (diff != 0) begin
                case (sec)
                    SEC_RED:   numer = 32'(diff) * 6 + 32'(g) - 32'(b);
                    SEC_GREEN: numer = 32'(diff) * 2 + 32'(b) - 32'(r);
                    default:   numer = 32'(diff) * 4 + 32'(r) - 32'(g);
                endcase
                quot    = (numer << FR) / (32'(diff) * 6);
                res.hue = quot[FR-1:0];
            end
            if (mx != 0) begin
                quot = (32'(diff) << FR) / 32'(mx);
                // min of zero gives exactly one full turn, clamp to all ones
                res.sat = (quot > 32'((1 << FR) - 1)) ? '1 : quot[FR-1:0];
            end
            res.bright = mx;
            return res;
        endfunction

        function void note_pixel(logic [CH-1:0] r, logic [CH-1:0] g, logic [CH-1:0] b);
            expected_hsv.push_back(hsv_of(r, g, b));
        endfunction

        function void check_result(hsv_t got);
            hsv_t want;
            bit   bad;
            if (expected_hsv.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no pixel pending: hue %h sat %h bright %h",
                             $realtime, got.hue, got.sat, got.bright);
                return;
            end
            want = expected_hsv.pop_front();
            bad  = (got.hue !== want.hue) || (got.sat !== want.sat)
                   || (got.bright !== want.bright);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch hue %h/%h sat %h/%h bright %h/%h (exp/act)",
                             $realtime, want.hue, got.hue, want.sat, got.sat,
                             want.bright, got.bright);
            end
        endfunction

        function int pending();
            return expected_hsv.size();
        endfunction
    endclass

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          start         = 1'b0;
    logic          busy;
    logic [CH-1:0] i_red_level   = '0;
    logic [CH-1:0] i_green_level = '0;
    logic [CH-1:0] i_blue_level  = '0;
    logic          o_valid;
    logic [FR-1:0] o_hue_turn;
    logic [FR-1:0] o_saturation_level;
    logic [CH-1:0] o_brightness_level;

    hsv_tracker pixel_book = new();

    rgb_to_hsv_pixel #(
        .CHANNEL_BITS  (CH),
        .FRACTION_BITS (FR)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_red_level        (i_red_level),
        .i_green_level      (i_green_level),
        .i_blue_level       (i_blue_level),
        .o_valid            (o_valid),
        .o_hue_turn         (o_hue_turn),
        .o_saturation_level (o_saturation_level),
        .o_brightness_level (o_brightness_level)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                pixel_book.check_result({o_hue_turn, o_saturation_level, o_brightness_level});
            if (start && !busy)
                pixel_book.note_pixel(i_red_level, i_green_level, i_blue_level);
        end
    end

    task automatic send_pixel(input logic [CH-1:0] r, input logic [CH-1:0] g,
                              input logic [CH-1:0] b, input bit may_idle);
        while (may_idle && $urandom_range(0, 99) < 37) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_red_level   <= r;
        i_green_level <= g;
        i_blue_level  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pixel_book.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [CH-1:0] r;
        logic [CH-1:0] g;
        logic [CH-1:0] b;
        logic [CH-1:0] a;
        logic [CH-1:0] c;
        int            mode;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (CORNER_PIXELS[k])
            send_pixel(CORNER_PIXELS[k][23:16], CORNER_PIXELS[k][15:8],
                       CORNER_PIXELS[k][7:0], 1'b1);

        for (int i = 0; i < 1300; i++) begin
            if (i == 300) begin
                // hold off until the pipeline has emptied
                start <= 1'b0;
                wait_drained();
            end
            mode = $urandom_range(0, 9);
            a    = CH'($urandom_range(0, (1 << CH) - 1));
            c    = CH'($urandom_range(0, (1 << CH) - 1));
            r    = CH'($urandom_range(0, (1 << CH) - 1));
            g    = CH'($urandom_range(0, (1 << CH) - 1));
            b    = CH'($urandom_range(0, (1 << CH) - 1));
            case (mode)
                6: begin
                    // two channels tied
                    case ($urandom_range(0, 2))
                        0:       begin r = a; g = a; b = c; end
                        1:       begin r = a; g = c; b = a; end
                        default: begin r = c; g = a; b = a; end
                    endcase
                end
                7: begin
                    r = a;
                    g = a;
                    b = a;
                end
                8: begin
                    r = CH'($urandom_range(0, 3));
                    g = CH'($urandom_range(0, 3));
                    b = CH'($urandom_range(0, 3));
                end
                9: begin
                    r = CH'($urandom_range((1 << CH) - 6, (1 << CH) - 1));
                    g = CH'($urandom_range((1 << CH) - 6, (1 << CH) - 1));
                    b = CH'($urandom_range((1 << CH) - 6, (1 << CH) - 1));
                end
                default: ;
            endcase
            send_pixel(r, g, b, !(i >= 500 && i < 800));
        end
        start <= 1'b0;

        wait_drained();
        repeat (LATENCY + 5) @(posedge i_clk);
        if (pixel_book.mismatches == 0 && pixel_book.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
design/rhsv_pkg.sv
design/rgb_to_hsv_pixel.sv
design/rhsv_checker.sv
bench/tb_top.sv
